>>> hdl/hidrd_pkg.sv
// shared constants and result type for the hid report descriptor parser
package hidrd_pkg;

  localparam int unsigned MAX_RECORDS = 256;
  localparam int unsigned REC_CNT_W   = $clog2(MAX_RECORDS + 1);
  localparam int unsigned PROD_W      = 19;

  localparam logic [7:0] LONG_PREFIX      = 8'hFE;
  localparam logic [7:0] TAG_MASK         = 8'hFC;
  localparam logic [7:0] TAG_USAGE_PAGE   = 8'h04;
  localparam logic [7:0] TAG_USAGE        = 8'h08;
  localparam logic [7:0] TAG_INPUT        = 8'h80;
  localparam logic [7:0] TAG_REPORT_ID    = 8'h84;
  localparam logic [7:0] TAG_REPORT_SIZE  = 8'h74;
  localparam logic [7:0] TAG_REPORT_COUNT = 8'h94;

  localparam logic [31:0] DIGITIZER_PAGE = 32'h0000_000D;
  localparam logic [31:0] HEATMAP_USAGE  = 32'h0000_006A;

  localparam logic [1:0] ROLE_NONE = 2'd0;
  localparam logic [1:0] ROLE_SYNC = 2'd1;
  localparam logic [1:0] ROLE_SUB  = 2'd2;

  typedef struct packed {
    logic        record_valid;
    logic [31:0] upage;
    logic [31:0] usage_id;
    logic [7:0]  rpt_id;
    logic [15:0] byte_size;
    logic [7:0]  record_index;
    logic [1:0]  heatmap_role;
    logic        descriptor_done;
    logic        heatmap_found;
  } result_t;

endpackage

>>> hdl/hid_report_descriptor_parser.sv
// hid report descriptor parser: item decode, global tracking and usage records
// one descriptor word accepted per cycle, back to back, while in_stall_o is low
// result word: registered in the output register, or held in the skid stage while stalled
// throughput: one word per cycle when not stalled; two-entry output and skid absorb stalls
// reset: asynchronous, clears parse state, tracked globals, record count and sync flag
module hid_report_descriptor_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  desc_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_valid_o,
  output logic [31:0] upage_o,
  output logic [31:0] usage_id_o,
  output logic [7:0]  rpt_id_o,
  output logic [15:0] byte_size_o,
  output logic [7:0]  record_index_o,
  output logic [1:0]  heatmap_role_o,
  output logic        descriptor_done_o,
  output logic        heatmap_found_o
);

  localparam logic [1:0] PH_PREFIX   = 2'd0;
  localparam logic [1:0] PH_LONG_LEN = 2'd1;
  localparam logic [1:0] PH_LONG_TAG = 2'd2;
  localparam logic [1:0] PH_DATA     = 2'd3;

  localparam int unsigned CW = hidrd_pkg::REC_CNT_W;
  localparam int unsigned PW = hidrd_pkg::PROD_W;
  localparam logic [CW-1:0] CNT_MAX  = CW'(hidrd_pkg::MAX_RECORDS);
  localparam logic [CW-1:0] CNT_LAST = CW'(hidrd_pkg::MAX_RECORDS - 1);

  logic [1:0]    phase_q, phase_d;
  logic [7:0]    left_q, left_d;
  logic [7:0]    prefix_q, prefix_d;
  logic [31:0]   accum_q, accum_d;
  logic [1:0]    pos_q, pos_d;
  logic [31:0]   page_q, page_d;
  logic [31:0]   usage_q, usage_d;
  logic [7:0]    rid_q, rid_d;
  logic [PW-1:0] size_q, size_d;
  logic [PW-1:0] count_q, count_d;
  logic [CW-1:0] rcnt_q, rcnt_d;
  logic          sync_q, sync_d;

  hidrd_pkg::result_t out_q, skid_q, res;
  logic               out_valid_q, skid_valid_q;

  logic          in_accept;
  logic          res_valid;
  logic          out_take;
  logic          apply_en;
  logic [7:0]    apply_prefix;
  logic [31:0]   apply_data;
  logic [7:0]    tag;
  logic          made;
  logic [1:0]    role;
  logic [CW-1:0] idx;
  logic [2*PW-1:0] prod;
  logic [7:0]    nbytes;

  assign in_accept = in_valid_i && !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign prod = size_q * count_q;

  always_comb begin
    phase_d  = first_byte_i ? PH_PREFIX : phase_q;
    left_d   = first_byte_i ? 8'd0 : left_q;
    prefix_d = first_byte_i ? 8'd0 : prefix_q;
    accum_d  = first_byte_i ? 32'd0 : accum_q;
    pos_d    = first_byte_i ? 2'd0 : pos_q;
    page_d   = first_byte_i ? 32'd0 : page_q;
    usage_d  = first_byte_i ? 32'd0 : usage_q;
    rid_d    = first_byte_i ? 8'd0 : rid_q;
    size_d   = first_byte_i ? '0 : size_q;
    count_d  = first_byte_i ? '0 : count_q;
    rcnt_d   = first_byte_i ? '0 : rcnt_q;
    sync_d   = first_byte_i ? 1'b0 : sync_q;

    apply_en     = 1'b0;
    apply_prefix = desc_byte_i;
    apply_data   = 32'd0;
    nbytes       = (desc_byte_i[1:0] == 2'd3) ? 8'd4 : {6'd0, desc_byte_i[1:0]};

    case (phase_d)
      PH_PREFIX: begin
        prefix_d = desc_byte_i;
        accum_d  = 32'd0;
        pos_d    = 2'd0;
        if (desc_byte_i == hidrd_pkg::LONG_PREFIX) begin
          phase_d = PH_LONG_LEN;
        end else if (nbytes == 8'd0) begin
          apply_en = 1'b1;
        end else begin
          left_d  = nbytes;
          phase_d = PH_DATA;
        end
      end
      PH_LONG_LEN: begin
        left_d  = desc_byte_i;
        phase_d = PH_LONG_TAG;
      end
      PH_LONG_TAG: begin
        phase_d = (left_d == 8'd0) ? PH_PREFIX : PH_DATA;
      end
      default: begin
        if (prefix_d != hidrd_pkg::LONG_PREFIX) begin
          accum_d[{pos_d, 3'b000} +: 8] = accum_d[{pos_d, 3'b000} +: 8] | desc_byte_i;
          pos_d = pos_d + 2'd1;
        end
        if (left_d != 8'd0) begin
          left_d = left_d - 8'd1;
        end
        if (left_d == 8'd0) begin
          phase_d = PH_PREFIX;
          if (prefix_d != hidrd_pkg::LONG_PREFIX) begin
            apply_en     = 1'b1;
            apply_prefix = prefix_d;
            apply_data   = accum_d;
          end
        end
      end
    endcase

    // apply a completed short item
    tag  = apply_prefix & hidrd_pkg::TAG_MASK;
    made = 1'b0;
    role = hidrd_pkg::ROLE_NONE;
    idx  = (rcnt_d < CNT_LAST) ? rcnt_d : CNT_LAST;
    if (apply_en) begin
      case (tag)
        hidrd_pkg::TAG_USAGE_PAGE:   page_d  = apply_data;
        hidrd_pkg::TAG_USAGE:        usage_d = apply_data;
        hidrd_pkg::TAG_REPORT_ID:    rid_d   = apply_data[7:0];
        hidrd_pkg::TAG_REPORT_SIZE:  size_d  = apply_data[PW-1:0];
        hidrd_pkg::TAG_REPORT_COUNT: count_d = apply_data[PW-1:0];
        hidrd_pkg::TAG_INPUT: begin
          made = 1'b1;
          if (page_d == hidrd_pkg::DIGITIZER_PAGE && usage_d == hidrd_pkg::HEATMAP_USAGE) begin
            role   = sync_d ? hidrd_pkg::ROLE_SUB : hidrd_pkg::ROLE_SYNC;
            sync_d = 1'b1;
          end
          if (rcnt_d < CNT_MAX) begin
            rcnt_d = rcnt_d + CW'(1);
          end
        end
        default: ;
      endcase
    end

    if (last_byte_i) begin
      phase_d = PH_PREFIX;
      left_d  = 8'd0;
      pos_d   = 2'd0;
      accum_d = 32'd0;
    end

    res = '0;
    if (made) begin
      res.record_valid = 1'b1;
      res.upage        = page_d;
      res.usage_id     = usage_d;
      res.rpt_id       = rid_d;
      res.byte_size    = first_byte_i ? 16'd0 : prod[PW-1:3];
      res.record_index = 8'(idx);
      res.heatmap_role = role;
    end
    res.descriptor_done = last_byte_i;
    res.heatmap_found   = sync_d;
  end

  assign res_valid = in_accept && (made || last_byte_i);
  assign out_take  = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_PREFIX;
      left_q   <= 8'd0;
      prefix_q <= 8'd0;
      accum_q  <= 32'd0;
      pos_q    <= 2'd0;
      page_q   <= 32'd0;
      usage_q  <= 32'd0;
      rid_q    <= 8'd0;
      size_q   <= '0;
      count_q  <= '0;
      rcnt_q   <= '0;
      sync_q   <= 1'b0;
    end else if (in_accept) begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      prefix_q <= prefix_d;
      accum_q  <= accum_d;
      pos_q    <= pos_d;
      page_q   <= page_d;
      usage_q  <= usage_d;
      rid_q    <= rid_d;
      size_q   <= size_d;
      count_q  <= count_d;
      rcnt_q   <= rcnt_d;
      sync_q   <= sync_d;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign record_valid_o    = out_q.record_valid;
  assign upage_o           = out_q.upage;
  assign usage_id_o        = out_q.usage_id;
  assign rpt_id_o          = out_q.rpt_id;
  assign byte_size_o       = out_q.byte_size;
  assign record_index_o    = out_q.record_index;
  assign heatmap_role_o    = out_q.heatmap_role;
  assign descriptor_done_o = out_q.descriptor_done;
  assign heatmap_found_o   = out_q.heatmap_found;

endmodule

>>> hdl/hidrd_checker.sv
// port-level checker for the hid report descriptor parser and its bind
module hidrd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  desc_byte_i,
  input logic        first_byte_i,
  input logic        last_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        record_valid_o,
  input logic [31:0] upage_o,
  input logic [31:0] usage_id_o,
  input logic [7:0]  rpt_id_o,
  input logic [15:0] byte_size_o,
  input logic [7:0]  record_index_o,
  input logic [1:0]  heatmap_role_o,
  input logic        descriptor_done_o,
  input logic        heatmap_found_o
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // a word carries a record, completion or both
  a_word_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> record_valid_o || descriptor_done_o)
    else $error("result word with neither record nor completion");

  // no record means zero record fields
  a_no_record_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !record_valid_o |-> upage_o == 32'd0 && usage_id_o == 32'd0 &&
      rpt_id_o == 8'd0 && byte_size_o == 16'd0 && record_index_o == 8'd0 &&
      heatmap_role_o == hidrd_pkg::ROLE_NONE)
    else $error("record fields set without a record");

  // a heatmap role implies the sync flag and a record
  a_role_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (heatmap_role_o == hidrd_pkg::ROLE_SYNC ||
      heatmap_role_o == hidrd_pkg::ROLE_SUB) |-> heatmap_found_o && record_valid_o)
    else $error("heatmap role without sync flag");

endmodule

bind hid_report_descriptor_parser hidrd_checker u_hidrd_checker (.*);

>>> tb/hid_report_descriptor_parser_test.sv
// self-checking testbench for the hid report descriptor parser with a built-in scan predictor
`timescale 1ns / 1ps

module hid_report_descriptor_parser_test;

  typedef enum logic [1:0] {DEC_PREFIX, DEC_LONG_LEN, DEC_LONG_TAG, DEC_DATA} dec_phase_e;

  typedef struct {
    logic [7:0] b;
    logic       first;
    logic       last;
    int         gap;
    bit         hold;
  } desc_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  desc_byte_i = 8'h00;
  logic        first_byte_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        record_valid_o;
  logic [31:0] upage_o;
  logic [31:0] usage_id_o;
  logic [7:0]  rpt_id_o;
  logic [15:0] byte_size_o;
  logic [7:0]  record_index_o;
  logic [1:0]  heatmap_role_o;
  logic        descriptor_done_o;
  logic        heatmap_found_o;

  hid_report_descriptor_parser u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .desc_byte_i       (desc_byte_i),
    .first_byte_i      (first_byte_i),
    .last_byte_i       (last_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .record_valid_o    (record_valid_o),
    .upage_o           (upage_o),
    .usage_id_o        (usage_id_o),
    .rpt_id_o          (rpt_id_o),
    .byte_size_o       (byte_size_o),
    .record_index_o    (record_index_o),
    .heatmap_role_o    (heatmap_role_o),
    .descriptor_done_o (descriptor_done_o),
    .heatmap_found_o   (heatmap_found_o)
  );

  always #5 clk_i = ~clk_i;

  // scanner state mirrored by the predictor
  dec_phase_e  dec_phase = DEC_PREFIX;
  logic [7:0]  remaining = '0;
  logic [7:0]  prefix_q = '0;
  logic [31:0] accum = '0;
  logic [1:0]  acc_pos = '0;
  logic [31:0] page_q = '0;
  logic [31:0] usage_q = '0;
  logic [7:0]  rid_q = '0;
  logic [31:0] rsize_q = '0;
  logic [31:0] rcount_q = '0;
  logic [8:0]  rec_total = '0;
  logic        sync_flag = 1'b0;

  hidrd_pkg::result_t expected_records[$];
  desc_word_t  desc_words[$];
  logic [7:0]  frag[$];

  int          mismatches = 0;
  int          words_taken = 0;
  int          total_words = 0;
  int          results_seen = 0;
  logic        in_took = 1'b0;
  logic        out_took = 1'b0;

  desc_word_t  cur_word;
  bit          word_loaded = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  hidrd_pkg::result_t want;

  function automatic int draw_wait(input int seq);
    return ((seq / 40) % 4 == 3) ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic decode_desc_byte(input logic [7:0] b, input logic first, input logic last);
    hidrd_pkg::result_t r;
    logic        made;
    logic        item_done;
    logic [63:0] prod;
    int          n;
    r = '0;
    made = 1'b0;
    item_done = 1'b0;
    if (first) begin
      dec_phase = DEC_PREFIX;
      remaining = '0;
      prefix_q = '0;
      accum = '0;
      acc_pos = '0;
      page_q = '0;
      usage_q = '0;
      rid_q = '0;
      rsize_q = '0;
      rcount_q = '0;
      rec_total = '0;
      sync_flag = 1'b0;
    end
    case (dec_phase)
      DEC_PREFIX: begin
        prefix_q = b;
        accum = '0;
        acc_pos = '0;
        if (b == hidrd_pkg::LONG_PREFIX) begin
          dec_phase = DEC_LONG_LEN;
        end else begin
          n = (b[1:0] == 2'd3) ? 4 : int'(b[1:0]);
          if (n == 0) begin
            item_done = 1'b1;
          end else begin
            remaining = 8'(n);
            dec_phase = DEC_DATA;
          end
        end
      end
      DEC_LONG_LEN: begin
        remaining = b;
        dec_phase = DEC_LONG_TAG;
      end
      DEC_LONG_TAG: begin
        dec_phase = (remaining == 0) ? DEC_PREFIX : DEC_DATA;
      end
      default: begin
        if (prefix_q != hidrd_pkg::LONG_PREFIX) begin
          accum = accum | ({24'd0, b} << {acc_pos, 3'b000});
          acc_pos = acc_pos + 2'd1;
        end
        if (remaining != 0) remaining = remaining - 8'd1;
        if (remaining == 0) begin
          dec_phase = DEC_PREFIX;
          if (prefix_q != hidrd_pkg::LONG_PREFIX) item_done = 1'b1;
        end
      end
    endcase
    if (item_done) begin
      case (prefix_q & hidrd_pkg::TAG_MASK)
        hidrd_pkg::TAG_USAGE_PAGE:   page_q = accum;
        hidrd_pkg::TAG_USAGE:        usage_q = accum;
        hidrd_pkg::TAG_REPORT_ID:    rid_q = accum[7:0];
        hidrd_pkg::TAG_REPORT_SIZE:  rsize_q = accum;
        hidrd_pkg::TAG_REPORT_COUNT: rcount_q = accum;
        hidrd_pkg::TAG_INPUT: begin
          made = 1'b1;
          r.record_valid = 1'b1;
          r.heatmap_role = hidrd_pkg::ROLE_NONE;
          if (page_q == hidrd_pkg::DIGITIZER_PAGE && usage_q == hidrd_pkg::HEATMAP_USAGE) begin
            if (!sync_flag) begin
              r.heatmap_role = hidrd_pkg::ROLE_SYNC;
              sync_flag = 1'b1;
            end else begin
              r.heatmap_role = hidrd_pkg::ROLE_SUB;
            end
          end
          r.record_index = (rec_total < hidrd_pkg::MAX_RECORDS - 1) ? rec_total[7:0] :
                           8'(hidrd_pkg::MAX_RECORDS - 1);
          if (rec_total < hidrd_pkg::MAX_RECORDS) rec_total = rec_total + 9'd1;
          prod = {32'd0, rsize_q} * {32'd0, rcount_q};
          r.upage = page_q;
          r.usage_id = usage_q;
          r.rpt_id = rid_q;
          r.byte_size = prod[18:3];
        end
        default: ;
      endcase
    end
    if (last) begin
      dec_phase = DEC_PREFIX;
      remaining = '0;
      acc_pos = '0;
      accum = '0;
    end
    if (made || last) begin
      r.descriptor_done = last;
      r.heatmap_found = sync_flag;
      expected_records = {expected_records, r};
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (act !== exp) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      mismatches++;
    end
  endtask

  task automatic put_short(input logic [7:0] tag, input logic [1:0] code, input logic [31:0] val);
    int n;
    n = (code == 2'd3) ? 4 : int'(code);
    frag = {frag, tag | {6'd0, code}};
    for (int i = 0; i < n; i++) frag = {frag, val[8*i +: 8]};
  endtask

  task automatic put_long(input int len);
    frag = {frag, hidrd_pkg::LONG_PREFIX};
    frag = {frag, 8'(len)};
    frag = {frag, 8'($urandom)};
    repeat (len) frag = {frag, 8'($urandom)};
  endtask

  task automatic flush_desc(input bit fresh, input bit hold, input bit noisy);
    desc_word_t w;
    foreach (frag[i]) begin
      w.b = frag[i];
      w.first = (i == 0) ? fresh : (noisy && $urandom_range(0, 299) == 0);
      w.last = (i == frag.size() - 1) ? 1'b1 : (noisy && $urandom_range(0, 299) == 0);
      w.hold = hold && i == 0;
      w.gap = draw_wait(desc_words.size());
      desc_words = {desc_words, w};
    end
    frag.delete();
  endtask

  function automatic logic [31:0] pick_value(input logic [7:0] tag);
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return 32'd0;
      2: begin
        if (tag == hidrd_pkg::TAG_USAGE_PAGE) return hidrd_pkg::DIGITIZER_PAGE;
        if (tag == hidrd_pkg::TAG_USAGE) return hidrd_pkg::HEATMAP_USAGE;
        return 32'($urandom_range(0, 255));
      end
      3: return 32'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  task automatic build_random_desc(input int n_items);
    logic [7:0] tag;
    repeat (n_items) begin
      case ($urandom_range(0, 15))
        0, 1:    tag = hidrd_pkg::TAG_USAGE_PAGE;
        2, 3:    tag = hidrd_pkg::TAG_USAGE;
        4:       tag = hidrd_pkg::TAG_REPORT_ID;
        5:       tag = hidrd_pkg::TAG_REPORT_SIZE;
        6:       tag = hidrd_pkg::TAG_REPORT_COUNT;
        7, 8, 9: tag = hidrd_pkg::TAG_INPUT;
        10: begin
          put_long(($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5));
          continue;
        end
        11, 12: begin
          frag = {frag, 8'($urandom)};
          continue;
        end
        default: begin
          put_short(hidrd_pkg::TAG_USAGE_PAGE, 2'($urandom_range(1, 3)),
                    hidrd_pkg::DIGITIZER_PAGE);
          put_short(hidrd_pkg::TAG_USAGE, 2'($urandom_range(1, 3)), hidrd_pkg::HEATMAP_USAGE);
          tag = hidrd_pkg::TAG_INPUT;
        end
      endcase
      put_short(tag, 2'($urandom_range(0, 3)), pick_value(tag));
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_took)) begin
      if (!word_loaded && desc_words.size() > 0) begin
        cur_word = desc_words.pop_front();
        word_loaded = 1;
        gap_left = cur_word.gap;
      end
      if (word_loaded && gap_left == 0 && (!cur_word.hold || expected_records.size() == 0)) begin
        in_valid_i <= 1'b1;
        desc_byte_i <= cur_word.b;
        first_byte_i <= cur_word.first;
        last_byte_i <= cur_word.last;
        word_loaded = 0;
      end else begin
        in_valid_i <= 1'b0;
        if (word_loaded && gap_left > 0) gap_left--;
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_took) stall_left = draw_wait(results_seen);
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_took <= out_valid_o && !out_stall_i;
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_records.size() == 0) begin
          $error("unexpected result word: record_valid %0h done %0h", record_valid_o,
                 descriptor_done_o);
          mismatches++;
        end else begin
          want = expected_records.pop_front();
          check_field("record_valid", want.record_valid, record_valid_o);
          check_field("upage", want.upage, upage_o);
          check_field("usage_id", want.usage_id, usage_id_o);
          check_field("rpt_id", want.rpt_id, rpt_id_o);
          check_field("byte_size", want.byte_size, byte_size_o);
          check_field("record_index", want.record_index, record_index_o);
          check_field("heatmap_role", want.heatmap_role, heatmap_role_o);
          check_field("descriptor_done", want.descriptor_done, descriptor_done_o);
          check_field("heatmap_found", want.heatmap_found, heatmap_found_o);
        end
      end
      in_took <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        decode_desc_byte(desc_byte_i, first_byte_i, last_byte_i);
        words_taken++;
      end
    end
  end

  initial begin
    int d;
    // one-word descriptor: record and completion together
    put_short(hidrd_pkg::TAG_INPUT, 2'd0, 32'd0);
    flush_desc(1'b1, 1'b0, 1'b0);
    put_short(hidrd_pkg::TAG_USAGE_PAGE, 2'd1, hidrd_pkg::DIGITIZER_PAGE);
    put_short(hidrd_pkg::TAG_USAGE, 2'd1, hidrd_pkg::HEATMAP_USAGE);
    put_short(hidrd_pkg::TAG_REPORT_SIZE, 2'd1, 32'd16);
    put_short(hidrd_pkg::TAG_REPORT_COUNT, 2'd1, 32'd3);
    put_short(hidrd_pkg::TAG_INPUT, 2'd1, 32'd2);
    put_short(hidrd_pkg::TAG_INPUT, 2'd0, 32'd0);
    put_short(hidrd_pkg::TAG_REPORT_ID, 2'd2, 32'h0000_1234);
    put_short(hidrd_pkg::TAG_REPORT_ID, 2'd0, 32'd0);
    put_long(1);
    put_short(hidrd_pkg::TAG_INPUT, 2'd0, 32'd0);
    // final item cut short
    put_short(hidrd_pkg::TAG_REPORT_COUNT, 2'd3, 32'h0100_0000);
    void'(frag.pop_back());
    void'(frag.pop_back());
    flush_desc(1'b1, 1'b0, 1'b0);

    d = 0;
    while (desc_words.size() < 1620) begin
      if (d == 2) begin
        // enough records to saturate the index
        put_short(hidrd_pkg::TAG_USAGE_PAGE, 2'd1, hidrd_pkg::DIGITIZER_PAGE);
        put_short(hidrd_pkg::TAG_USAGE, 2'd1, hidrd_pkg::HEATMAP_USAGE);
        repeat (280) put_short(hidrd_pkg::TAG_INPUT, 2'd0, 32'd0);
      end else begin
        build_random_desc($urandom_range(1, 40));
      end
      if (frag.size() > 4 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) void'(frag.pop_back());
      end
      flush_desc($urandom_range(0, 9) != 0, d == 0 || $urandom_range(0, 9) == 0, 1'b1);
      d++;
    end
    total_words = desc_words.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (words_taken != total_words) @(posedge clk_i);
    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
hdl/hidrd_pkg.sv
hdl/hid_report_descriptor_parser.sv
hdl/hidrd_checker.sv
tb/hid_report_descriptor_parser_test.sv
